FILE: design/float32_to_half_converter_core_macros.svh
// Assertion macros for the float32 to half converter core.
// Included by the top level; no other dependencies.
`ifndef FLOAT32_TO_HALF_CONVERTER_CORE_MACROS_SVH
`define FLOAT32_TO_HALF_CONVERTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define F2H_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define F2H_ASSERT_RESET(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) prop) else $error("reset assertion failed");
`else
`define F2H_ASSERT_IMPL(label, clk, rst_n, prop)
`define F2H_ASSERT_RESET(label, clk, rst_n, prop)
`endif
`endif

FILE: design/f2h_pkg.sv
// Shared constants and types for the float32 to half converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package f2h_pkg;
	localparam logic [31:0] MAG_MASK     = 32'h7FFF_FFFF;
	localparam logic [31:0] INF_PATTERN  = 32'h7F80_0000;
	localparam logic [31:0] MAX_HALF_PAT = 32'h477F_E000;
	localparam logic [8:0]  REBIAS       = 9'd112;
	localparam logic [15:0] OVF_HALF     = 16'hFFFF;

	typedef struct packed {
		logic [15:0] half_bits;
		logic        overflowed;
	} f2h_result_t;
endpackage
`default_nettype wire

FILE: design/float32_to_half_converter_core.sv
// Float32 to half converter top level: input register, converter, output register.
// Depends on f2h_pkg, f2h_convert and the assertion macro header.
//
// Usage:
//   Input channel: single_bits with in_valid / in_stall. A transaction is
//   taken at a clock edge where in_valid is high and in_stall is low.
//   Output channel: half_bits and overflowed with out_valid / out_stall.
//   Path: an accepted input passes through the input register, the
//   converter and the result register before it reaches the output.
//   Throughput: one transaction per cycle while out_stall is low; the input
//   register and the result register form a two-stage pipeline that
//   advances whenever the downstream stage is empty or being drained.
//   Stall: when out_stall is high with out_valid high, the result register holds its value;
//   the input register still accepts while it is empty, then in_stall rises.
//   Reset: arst_n low clears both valid flags asynchronously; no
//   transaction is lost or invented across reset release.
`timescale 1ns / 1ps
`default_nettype none
`include "float32_to_half_converter_core_macros.svh"
module float32_to_half_converter_core import f2h_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] single_bits,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      half_bits,
	output logic             overflowed
);
	logic        valid_s1;
	logic [31:0] bits_s1;
	logic        valid_s2;
	f2h_result_t res_s2;
	f2h_result_t res_c;
	logic        adv_s2;
	logic        adv_s1;

	assign adv_s2 = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign adv_s1 = in_valid && !in_stall;

	f2h_convert u_convert (
		.single_bits(bits_s1),
		.result(res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s2) valid_s2 <= valid_s1;
			if (!in_stall) valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) bits_s1 <= single_bits;
		if (adv_s2 && valid_s1) res_s2 <= res_c;
	end

	assign out_valid = valid_s2;
	assign half_bits = res_s2.half_bits;
	assign overflowed = res_s2.overflowed;

	`F2H_ASSERT_IMPL(a_ovf_pattern, clk, arst_n, out_valid && overflowed |-> half_bits == OVF_HALF)
	`F2H_ASSERT_IMPL(a_stall_only_full, clk, arst_n, in_stall |-> valid_s1 && valid_s2)
	`F2H_ASSERT_IMPL(a_hold_on_stall, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(half_bits))
	`F2H_ASSERT_RESET(a_reset_empty, clk, arst_n, !arst_n |=> !out_valid && !in_stall)
endmodule
`default_nettype wire

FILE: design/f2h_convert.sv
// Combinational binary32 to binary16 conversion with half-up guard rounding.
// Depends on f2h_pkg.
`timescale 1ns / 1ps
`default_nettype none
module f2h_convert import f2h_pkg::*; (
	input  wire logic [31:0] single_bits,
	output f2h_result_t      result
);
	logic [30:0] mag;
	logic        sign;
	logic [9:0]  e;
	logic [10:0] sig_n;
	logic [3:0]  sh;
	logic [10:0] sig_sh;
	logic        guard;
	logic [11:0] sig_r;
	logic [4:0]  e_base;
	logic [4:0]  e_out;
	logic [9:0]  f_out;

	always_comb begin
		mag = single_bits[30:0];
		sign = single_bits[31];
		e = {2'b00, mag[30:23]} - {1'b0, REBIAS};
		sig_n = {1'b1, mag[22:13]};
		sh = 4'(10'd1 - e);
		sig_sh = sig_n >> sh;
		guard = 1'b0;
		e_base = 5'd0;
		if (!e[9] && e != 10'd0) begin
			guard = mag[12];
			sig_r = {1'b0, sig_n} + 12'(guard);
			e_base = e[4:0];
		end else begin
			guard = sig_n[sh - 4'd1];
			sig_r = {1'b0, sig_sh} + 12'(guard);
			e_base = sig_r[10] ? 5'd1 : 5'd0;
		end
		e_out = e_base;
		f_out = sig_r[9:0];
		if (sig_r[11]) begin
			e_out = e_base + 5'd1;
			f_out = sig_r[10:1];
		end
		result.overflowed = 1'b0;
		result.half_bits = {sign, e_out, f_out};
		if ({1'b0, mag} > INF_PATTERN) begin
			result.half_bits = 16'd0;
		end else if ({1'b0, mag} > MAX_HALF_PAT) begin
			result.half_bits = OVF_HALF;
			result.overflowed = 1'b1;
		end else if (mag == 31'd0 || ($signed(e) < -10'sd9)) begin
			result.half_bits = 16'd0;
		end
	end
endmodule
`default_nettype wire
